FILE: rtl/lfgap_pkg.sv
// Shared types and constants of the gap-modulated field encoder.
package lfgap_pkg;

  localparam int DATA_W    = 32;
  localparam int TIME_W    = 12;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_REGS  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_START_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_ON   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_ON    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_GAP = 2'd3;

  localparam logic [TIME_W-1:0] RST_START_GAP = 12'd240;
  localparam logic [TIME_W-1:0] RST_ZERO_ON   = 12'd192;
  localparam logic [TIME_W-1:0] RST_ONE_ON    = 12'd448;
  localparam logic [TIME_W-1:0] RST_WRITE_GAP = 12'd136;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_ON    = 4'b0100,
    PH_GAP   = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   done;
  } enter_ctl_t;

endpackage

FILE: rtl/lfgap_enter.sv
// Selects the next bit phase of nonzero length, skipping empty bits.
module lfgap_enter #(
  parameter int MAX_BITS   = 32,
  parameter int TIMER_BITS = 12,
  parameter int BL_W       = $clog2(MAX_BITS + 1),
  parameter int IDX_W      = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1
) (
  input  logic [BL_W-1:0]             bits_in,
  input  logic [lfgap_pkg::DATA_W-1:0] word,
  input  logic [TIMER_BITS-1:0]       zero_on,
  input  logic [TIMER_BITS-1:0]       one_on,
  input  logic [TIMER_BITS-1:0]       gap,
  output lfgap_pkg::enter_ctl_t       ctl,
  output logic [TIMER_BITS-1:0]       timer,
  output logic [BL_W-1:0]             bits_out
);

  logic [MAX_BITS-1:0] wide;
  logic                zero_nz;
  logic                one_nz;
  logic                gap_nz;
  logic                found;
  logic [IDX_W-1:0]    idx;
  logic                top_bit;

  for (genvar g = 0; g < MAX_BITS; g++) begin : g_wide
    if (g < lfgap_pkg::DATA_W) begin : g_data
      assign wide[g] = word[g];
    end else begin : g_pad
      assign wide[g] = 1'b0;
    end
  end

  assign zero_nz = |zero_on;
  assign one_nz  = |one_on;
  assign gap_nz  = |gap;
  assign top_bit = wide[IDX_W'(bits_in - 1'b1)];

  // highest bit below bits_in whose on time is nonzero
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (i < int'(bits_in) && (wide[i] ? one_nz : zero_nz)) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctl.phase = lfgap_pkg::PH_IDLE;
    ctl.done  = 1'b1;
    timer     = '0;
    bits_out  = '0;
    if (bits_in != '0) begin
      if (gap_nz) begin
        ctl.done = 1'b0;
        bits_out = bits_in;
        if (top_bit ? one_nz : zero_nz) begin
          ctl.phase = lfgap_pkg::PH_ON;
          timer     = top_bit ? one_on : zero_on;
        end else begin
          ctl.phase = lfgap_pkg::PH_GAP;
          timer     = gap;
        end
      end else if (found) begin
        ctl.phase = lfgap_pkg::PH_ON;
        ctl.done  = 1'b0;
        timer     = wide[idx] ? one_on : zero_on;
        bits_out  = BL_W'(idx) + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lf_gap_bit_transmitter.sv
// Top level of the gap-modulated downlink encoder for a low-frequency reader field.
//
//  channel   | handshake             | payload
//  request   | req_valid / req_stall | cmd, data_word, bit_count, with_start
//  result    | rsp_valid / rsp_stall | field_enable, busy_res, finished, rejected
//  config    | cfg_we                | cfg_index, cfg_data
//
// One request per cycle while req_stall is low; its result passes the input
// register, then the result register holding the encoder state update.
// rst clears the handshake, the encoder state and loads the default timings.
// A stalled result holds; the input register keeps taking requests while empty
// or while the result register can advance.
module lf_gap_bit_transmitter #(
  parameter int MAX_BITS   = 32,
  parameter int TIMER_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                cmd,
  input  logic [lfgap_pkg::DATA_W-1:0]        data_word,
  input  logic [lfgap_pkg::COUNT_W-1:0]       bit_count,
  input  logic                                with_start,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                field_enable,
  output logic                                busy_res,
  output logic                                finished,
  output logic                                rejected,
  input  logic                                cfg_we,
  input  logic [lfgap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfgap_pkg::TIME_W-1:0]        cfg_data
);

  localparam int BL_W = $clog2(MAX_BITS + 1);

  logic [lfgap_pkg::TIME_W-1:0] start_gap_time;
  logic [lfgap_pkg::TIME_W-1:0] zero_on_time;
  logic [lfgap_pkg::TIME_W-1:0] one_on_time;
  logic [lfgap_pkg::TIME_W-1:0] write_gap_time;

  logic [TIMER_BITS-1:0] start_c;
  logic [TIMER_BITS-1:0] zero_c;
  logic [TIMER_BITS-1:0] one_c;
  logic [TIMER_BITS-1:0] gap_c;

  logic                           hold_valid;
  logic                           hold_cmd;
  logic [lfgap_pkg::DATA_W-1:0]   hold_data;
  logic [lfgap_pkg::COUNT_W-1:0]  hold_count;
  logic                           hold_start;

  lfgap_pkg::phase_t              phase, phase_next;
  logic [TIMER_BITS-1:0]          phase_timer, phase_timer_next;
  logic [lfgap_pkg::DATA_W-1:0]   shift_word, shift_word_next;
  logic [BL_W-1:0]                bits_left, bits_left_next;

  logic                           field_next;
  logic                           finished_next;
  logic                           rejected_next;

  logic                           advance;
  logic                           process;
  logic                           req_take;
  logic [BL_W-1:0]                count_sat;
  logic [TIMER_BITS-1:0]          timer_dec;
  logic [BL_W-1:0]                enter_n;
  logic [lfgap_pkg::DATA_W-1:0]   enter_w;
  lfgap_pkg::enter_ctl_t          enter_ctl;
  logic [TIMER_BITS-1:0]          enter_timer;
  logic [BL_W-1:0]                enter_bits;

  // saturate the 12-bit timings to the timer range
  if (TIMER_BITS >= lfgap_pkg::TIME_W) begin : g_time_ext
    assign start_c = TIMER_BITS'(start_gap_time);
    assign zero_c  = TIMER_BITS'(zero_on_time);
    assign one_c   = TIMER_BITS'(one_on_time);
    assign gap_c   = TIMER_BITS'(write_gap_time);
  end else begin : g_time_sat
    assign start_c = ((start_gap_time >> TIMER_BITS) != '0) ? '1
                                                            : start_gap_time[TIMER_BITS-1:0];
    assign zero_c  = ((zero_on_time >> TIMER_BITS) != '0) ? '1
                                                          : zero_on_time[TIMER_BITS-1:0];
    assign one_c   = ((one_on_time >> TIMER_BITS) != '0) ? '1
                                                         : one_on_time[TIMER_BITS-1:0];
    assign gap_c   = ((write_gap_time >> TIMER_BITS) != '0) ? '1
                                                            : write_gap_time[TIMER_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_gap_time <= lfgap_pkg::RST_START_GAP;
      zero_on_time   <= lfgap_pkg::RST_ZERO_ON;
      one_on_time    <= lfgap_pkg::RST_ONE_ON;
      write_gap_time <= lfgap_pkg::RST_WRITE_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        lfgap_pkg::REG_START_GAP: start_gap_time <= cfg_data;
        lfgap_pkg::REG_ZERO_ON:   zero_on_time   <= cfg_data;
        lfgap_pkg::REG_ONE_ON:    one_on_time    <= cfg_data;
        lfgap_pkg::REG_WRITE_GAP: write_gap_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = hold_valid && !advance;
  assign req_take  = req_valid && !req_stall;
  assign process   = hold_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= req_take || (hold_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      hold_cmd   <= cmd;
      hold_data  <= data_word;
      hold_count <= bit_count;
      hold_start <= with_start;
    end
  end

  assign count_sat = ({1'b0, hold_count} > (lfgap_pkg::COUNT_W + 1)'(MAX_BITS))
                   ? BL_W'(MAX_BITS) : BL_W'(hold_count);
  assign timer_dec = phase_timer - 1'b1;

  always_comb begin
    if (hold_cmd) begin
      enter_n = count_sat;
      enter_w = hold_data;
    end else if (phase == lfgap_pkg::PH_START) begin
      enter_n = bits_left;
      enter_w = shift_word;
    end else begin
      enter_n = (bits_left != '0) ? bits_left - 1'b1 : bits_left;
      enter_w = shift_word;
    end
  end

  lfgap_enter #(
    .MAX_BITS   (MAX_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_enter (
    .bits_in  (enter_n),
    .word     (enter_w),
    .zero_on  (zero_c),
    .one_on   (one_c),
    .gap      (gap_c),
    .ctl      (enter_ctl),
    .timer    (enter_timer),
    .bits_out (enter_bits)
  );

  always_comb begin
    phase_next       = phase;
    phase_timer_next = phase_timer;
    shift_word_next  = shift_word;
    bits_left_next   = bits_left;
    finished_next    = 1'b0;
    rejected_next    = 1'b0;
    if (hold_cmd) begin
      if (phase != lfgap_pkg::PH_IDLE) begin
        rejected_next = 1'b1;
      end else begin
        shift_word_next = hold_data;
        if (hold_start && (start_c != '0)) begin
          phase_next       = lfgap_pkg::PH_START;
          phase_timer_next = start_c;
          bits_left_next   = count_sat;
        end else begin
          phase_next       = enter_ctl.phase;
          phase_timer_next = enter_timer;
          bits_left_next   = enter_bits;
          finished_next    = enter_ctl.done;
        end
      end
    end else if (phase != lfgap_pkg::PH_IDLE) begin
      if (timer_dec != '0) begin
        phase_timer_next = timer_dec;
      end else if (phase == lfgap_pkg::PH_ON && gap_c != '0) begin
        phase_next       = lfgap_pkg::PH_GAP;
        phase_timer_next = gap_c;
      end else begin
        phase_next       = enter_ctl.phase;
        phase_timer_next = enter_timer;
        bits_left_next   = enter_bits;
        finished_next    = enter_ctl.done;
      end
    end
  end

  // on a tick the level is that of the running phase, on a command the new one
  always_comb begin
    case (hold_cmd ? phase_next : phase)
      lfgap_pkg::PH_START, lfgap_pkg::PH_GAP: field_next = 1'b0;
      default:                                 field_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lfgap_pkg::PH_IDLE;
      phase_timer <= '0;
      shift_word  <= '0;
      bits_left   <= '0;
    end else if (process) begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      shift_word  <= shift_word_next;
      bits_left   <= bits_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= process;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      field_enable <= field_next;
      busy_res     <= (phase_next != lfgap_pkg::PH_IDLE);
      finished     <= finished_next;
      rejected     <= rejected_next;
    end
  end

endmodule

FILE: rtl/lfgap_check.sv
// Port-level checks of the gap-modulated field encoder, bound to the top level.
module lfgap_check (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input logic field_enable,
  input logic busy_res,
  input logic finished,
  input logic rejected
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(field_enable) && $stable(busy_res)
                               && $stable(finished) && $stable(rejected))
    else $error("stalled result changed");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && finished |-> !busy_res && !rejected)
    else $error("finished while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rejected |-> busy_res)
    else $error("request rejected while idle");

  // the last write gap may end the send on the same tick
  a_gap_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !field_enable |-> busy_res || finished)
    else $error("field cut with no send running");

endmodule

bind lf_gap_bit_transmitter lfgap_check u_check (.*);
